FILE: hdl/cbts_pkg.sv
package cbts_pkg;

    // Field widths of the ports.
    localparam int CLK_W      = 30;
    localparam int RATE_W     = 20;
    localparam int PSC_W      = 10;
    localparam int SEG1_W     = 9;
    localparam int SEG2_W     = 8;
    localparam int SJW_W      = 3;
    localparam int WORD_W     = 32;
    localparam int TOTAL_W    = 5;

    // Search limits and rounding constants.
    localparam int MAX_PRESCALER   = 512;
    localparam int TOTAL_MIN       = 8;
    localparam int TOTAL_MAX       = 25;
    localparam int SAMPLE_PERMILLE = 750;
    localparam int SJW_LIMIT       = 4;
    localparam logic [CLK_W-1:0] KERNEL_CLOCK_RESET = 30'd80000000;

    // Serial divider step counter width.
    localparam int DIV_CNT_W = $clog2(CLK_W + 1);

    // Request to the serial divider.
    typedef struct packed {
        logic              start;
        logic [CLK_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_req;

    // Response from the serial divider, valid while done is high.
    typedef struct packed {
        logic              done;
        logic [CLK_W-1:0]  quotient;
        logic [RATE_W-1:0] remainder;
    } t_div_rsp;

    // Sample point in quanta: round(total * 750 / 1000), clamped to 2 .. total-1.
    // The rounded product equals (3 * total + 2) / 4 rounded down.
    function automatic logic [TOTAL_W-1:0] sample_point(input logic [TOTAL_W-1:0] total);
        logic [7:0] sp;
        sp = ({3'b000, total} + {2'b00, total, 1'b0} + 8'd2) >> 2;
        if (sp < 8'd2) begin
            sp = 8'd2;
        end
        if (sp >= {3'b000, total}) begin
            sp = {3'b000, total} - 8'd1;
        end
        return sp[TOTAL_W-1:0];
    endfunction

endpackage

FILE: hdl/can_bit_timing_search_top.sv
// CAN nominal bit timing search.
//
// Command channel: present the bitrate on i_bitrate and raise i_start; the
// transfer happens at a clock edge where i_start is high and o_busy is low.
// Each command gives exactly one result, shown for a single cycle with
// o_strobe high. The receiver cannot stall, so the result must be taken then.
// The kernel clock register is written through i_cfg_wr_en / i_cfg_wr_data;
// the user writes it only while the block is idle, which the block itself does not enforce; it resets to 80 MHz.
//
// A zero bitrate gives its result in the cycle after the transfer.
// Otherwise the kernel clock is first divided by the bitrate, then the
// quotient is divided by each candidate quanta count from 25 down to 8; the
// first exact quotient within the prescaler range is the smallest prescaler.
// Every division runs on one bit-serial divider (the quotient steps, then
// the done flag), and the result is then registered. o_busy stays high
// while a search runs and drops in the cycle the result is shown, so one
// item is handled at a time.
// Reset returns the controller to idle and drops any search in progress.
module can_bit_timing_search_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cbts_pkg::CLK_W-1:0]    i_cfg_wr_data,
    input  logic                          i_start,
    input  logic [cbts_pkg::RATE_W-1:0]   i_bitrate,
    output logic                          o_busy,
    output logic                          o_strobe,
    output logic                          o_found,
    output logic [cbts_pkg::WORD_W-1:0]   o_timing_word,
    output logic [cbts_pkg::PSC_W-1:0]    o_prescaler,
    output logic [cbts_pkg::SEG1_W-1:0]   o_segment_one,
    output logic [cbts_pkg::SEG2_W-1:0]   o_segment_two,
    output logic [cbts_pkg::SJW_W-1:0]    o_jump_width
);
    import cbts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_DIV_RATE = 3'b010,
        S_DIV_TOT  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CLK_W-1:0]     r_kernel_clock_hz;
    logic [CLK_W-1:0]     r_q, n_q;
    logic [TOTAL_W-1:0]   r_total, n_total;

    logic                 r_strobe, n_strobe;
    logic                 r_found, n_found;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [PSC_W-1:0]     r_psc, n_psc;
    logic [SEG1_W-1:0]    r_seg1, n_seg1;
    logic [SEG2_W-1:0]    r_seg2, n_seg2;
    logic [SJW_W-1:0]     r_sjw, n_sjw;

    t_div_req             w_req;
    t_div_rsp             w_rsp;
    logic                 w_accept;
    logic                 w_hit;
    logic [TOTAL_W-1:0]   w_sp;
    logic [TOTAL_W-1:0]   w_s1;
    logic [TOTAL_W-1:0]   w_s2;
    logic [SJW_W-1:0]     w_sjw;
    logic [PSC_W-1:0]     w_psc;

    cbts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept = i_start && (r_state == S_IDLE);

    // Kernel clock register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_clock_hz <= KERNEL_CLOCK_RESET;
        end else if (i_cfg_wr_en) begin
            r_kernel_clock_hz <= i_cfg_wr_data;
        end
    end

    // Candidate check: exact quotient that is a prescaler in range.
    assign w_psc = w_rsp.quotient[PSC_W-1:0];
    assign w_hit = (w_rsp.remainder == '0) && (w_rsp.quotient != '0) &&
                   (w_rsp.quotient <= CLK_W'(MAX_PRESCALER));

    // Segment values for the current quanta count.
    assign w_sp  = sample_point(r_total);
    assign w_s1  = w_sp - 1'b1;
    assign w_s2  = r_total - w_sp;
    assign w_sjw = (w_s2 < TOTAL_W'(SJW_LIMIT)) ? w_s2[SJW_W-1:0] : SJW_W'(SJW_LIMIT);

    // Search sequencer and result staging.
    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_total  = r_total;
        n_strobe = 1'b0;
        n_found  = 1'b0;
        n_word   = '0;
        n_psc    = '0;
        n_seg1   = '0;
        n_seg2   = '0;
        n_sjw    = '0;
        w_req.start    = 1'b0;
        w_req.dividend = r_q;
        w_req.divisor  = RATE_W'(r_total);
        unique case (r_state)
            S_IDLE: begin
                w_req.dividend = r_kernel_clock_hz;
                w_req.divisor  = i_bitrate;
                if (w_accept) begin
                    if (i_bitrate == '0) begin
                        n_strobe = 1'b1;
                    end else begin
                        w_req.start = 1'b1;
                        n_state     = S_DIV_RATE;
                    end
                end
            end
            S_DIV_RATE: begin
                w_req.divisor = RATE_W'(TOTAL_MAX);
                if (w_rsp.done) begin
                    if ((w_rsp.remainder != '0) || (w_rsp.quotient == '0)) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        w_req.start    = 1'b1;
                        w_req.dividend = w_rsp.quotient;
                        n_q            = w_rsp.quotient;
                        n_total        = TOTAL_W'(TOTAL_MAX);
                        n_state        = S_DIV_TOT;
                    end
                end
            end
            S_DIV_TOT: begin
                w_req.divisor = RATE_W'(r_total - 1'b1);
                if (w_rsp.done) begin
                    if (w_hit) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b1;
                        n_psc    = w_psc;
                        n_seg1   = SEG1_W'(w_s1);
                        n_seg2   = SEG2_W'(w_s2);
                        n_sjw    = w_sjw;
                        n_word   = {7'(w_sjw - 1'b1), 9'(w_psc - 1'b1),
                                    8'(w_s1 - 1'b1), 1'b0, 7'(w_s2 - 1'b1)};
                        n_state  = S_IDLE;
                    end else if (r_total == TOTAL_W'(TOTAL_MIN)) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        w_req.start = 1'b1;
                        n_total     = r_total - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_total <= n_total;
        if (n_strobe) begin
            r_found <= n_found;
            r_word  <= n_word;
            r_psc   <= n_psc;
            r_seg1  <= n_seg1;
            r_seg2  <= n_seg2;
            r_sjw   <= n_sjw;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_found       = r_found;
    assign o_timing_word = r_word;
    assign o_prescaler   = r_psc;
    assign o_segment_one = r_seg1;
    assign o_segment_two = r_seg2;
    assign o_jump_width  = r_sjw;

    // A result is shown only once the search has finished.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result shown while search still running");

    // Every accepted command either starts a search or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_strobe))
        else $error("accepted command neither searched nor answered");

    // A rejected request carries an all-zero result.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_timing_word == '0 && o_prescaler == '0 &&
                                    o_jump_width == '0))
        else $error("rejected result carries non-zero fields");

    // A found setting has a real prescaler and a jump width within its limit.
    a_found_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (o_prescaler != '0 && o_jump_width != '0 &&
                                   o_jump_width <= SJW_W'(SJW_LIMIT)))
        else $error("found setting out of range");

    // The divider only completes while a search is waiting for it.
    a_div_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV_RATE || r_state == S_DIV_TOT))
        else $error("divider finished with no search in progress");

endmodule

FILE: hdl/cbts_div.sv
module cbts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbts_pkg::t_div_req i_req,
    output cbts_pkg::t_div_rsp o_rsp
);
    import cbts_pkg::*;

    logic [CLK_W-1:0]     r_num;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic [RATE_W:0]      w_shift;
    logic [RATE_W+1:0]    w_diff;
    logic                 w_qbit;

    // One restoring division step: bring down the next dividend bit and trial-subtract.
    assign w_shift = {r_rem, r_num[CLK_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_divisor};
    assign w_qbit  = ~w_diff[RATE_W+1];

    // Control: a run of CLK_W steps, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(CLK_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_run) begin
            r_num <= {r_num[CLK_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[RATE_W-1:0] : w_shift[RATE_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

endmodule
